// ===== sv/hsj_pkg.sv =====
// Shared types and constants for the Halton subpixel jitter block.
`timescale 1ns / 1ps

package hsj_pkg;

    localparam int FRAME_W    = 64;
    localparam int JIT_W      = 32;
    localparam int SEQ_W      = 7;
    localparam int SIZE_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd2;

    localparam logic [SEQ_W-1:0]  SEQ_LEN_RST = 7'd8;
    localparam logic [SIZE_W-1:0] WIDTH_RST   = 15'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST  = 15'd1080;

    localparam int MAX_SEQUENCE_DEF  = 64;
    localparam int FRACTION_BITS_DEF = 30;

    // Reciprocal of three for the base-3 digit step.
    localparam int RECIP3       = 21846;
    localparam int RECIP3_SHIFT = 16;

    localparam int DIV_NUMW  = 64;
    localparam int DIV_STEPW = 7;

    typedef struct packed {
        logic                 start;
        logic [DIV_STEPW-1:0] steps;
    } t_div_req;

endpackage

// ===== sv/hsj_ifs.sv =====
// Valid/ready channel interfaces for frame numbers and jitter pairs.
`timescale 1ns / 1ps

interface hsj_in_if;
    import hsj_pkg::*;
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_number;
    modport source (output valid, output frame_number, input ready);
    modport sink (input valid, input frame_number, output ready);
endinterface

interface hsj_out_if;
    import hsj_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [JIT_W-1:0] jitter_x;
    logic signed [JIT_W-1:0] jitter_y;
    modport source (output valid, output jitter_x, output jitter_y, input ready);
    modport sink (input valid, input jitter_x, input jitter_y, output ready);
endinterface

// ===== sv/hsj_div.sv =====
// Iterative restoring divider shared by the modulo and the jitter divisions.
`timescale 1ns / 1ps

module hsj_div #(
    parameter int DVW = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hsj_pkg::t_div_req             i_req,
    input  logic [hsj_pkg::DIV_NUMW-1:0]  i_num,
    input  logic [DVW-1:0]                i_den,
    output logic                          o_done,
    output logic [hsj_pkg::DIV_NUMW-1:0]  o_quo,
    output logic [DVW-1:0]                o_rem
);
    import hsj_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_STEPW-1:0] r_cnt;
    logic [DIV_NUMW-1:0]  r_quo;
    logic [DVW-1:0]       r_rem;
    logic [DVW-1:0]       r_den;

    logic [DVW:0]         shifted;
    logic                 ge;
    logic [DVW:0]         diff;
    logic [DVW-1:0]       n_rem;
    logic [DIV_NUMW-1:0]  n_quo;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_NUMW-1]};
        ge      = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
        n_rem   = ge ? diff[DVW-1:0] : shifted[DVW-1:0];
        n_quo   = {r_quo[DIV_NUMW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt  <= r_cnt - DIV_STEPW'(1);
                r_busy <= (r_cnt != DIV_STEPW'(1));
                r_done <= (r_cnt == DIV_STEPW'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== sv/halton_subpixel_jitter.sv =====
// Top level: Halton base-2/base-3 subpixel jitter with a shared iterative divider.
// Results pass through the shared restoring divider, which is skipped when the jitter is forced to zero.
// A new frame number is taken only in the idle state, so one frame is processed at a time;
// a result not yet taken holds the block. Synchronous reset loads the register defaults.
`timescale 1ns / 1ps

module halton_subpixel_jitter #(
    parameter int MAX_SEQUENCE  = hsj_pkg::MAX_SEQUENCE_DEF,
    parameter int FRACTION_BITS = hsj_pkg::FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hsj_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hsj_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hsj_in_if.sink                         i_in,
    hsj_out_if.source                      o_out
);
    import hsj_pkg::*;

    localparam int NB    = $clog2(MAX_SEQUENCE + 1);
    localparam int CW    = (NB > SEQ_W) ? NB : SEQ_W;
    localparam int DENW  = NB + 2;
    localparam int PRODW = DENW + SIZE_W;
    localparam int DVW   = PRODW + 1;
    localparam int NUMD  = DENW + FRACTION_BITS + 2;
    localparam int P3W   = NB + 15;

    localparam logic [DIV_NUMW-1:0] POS_LIM = DIV_NUMW'(64'h7FFF_FFFF);
    localparam logic [DIV_NUMW-1:0] NEG_LIM = DIV_NUMW'(64'h8000_0000);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MODS = 3'd1;
    localparam logic [2:0] S_MODW = 3'd2;
    localparam logic [2:0] S_RAD  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIVS = 3'd5;
    localparam logic [2:0] S_DIVW = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]          r_state;
    logic [SEQ_W-1:0]    r_seq_len;
    logic [SIZE_W-1:0]   r_width;
    logic [SIZE_W-1:0]   r_height;
    logic [FRAME_W-1:0]  r_frame;
    logic [NB-1:0]       r_n2;
    logic [NB-1:0]       r_n3;
    logic [DENW-1:0]     r_a2;
    logic [DENW-1:0]     r_d2;
    logic [DENW-1:0]     r_a3;
    logic [DENW-1:0]     r_d3;
    logic                r_axis;
    logic                r_neg;
    logic [DENW-1:0]     r_mag;
    logic [PRODW-1:0]    r_div;
    logic [JIT_W-1:0]    r_jx;
    logic [JIT_W-1:0]    r_jy;
    logic                r_out_valid;
    logic [JIT_W-1:0]    r_out_x;
    logic [JIT_W-1:0]    r_out_y;

    logic [CW-1:0]       seq_ext;
    logic [CW-1:0]       len_eff;
    logic                zero_case;
    logic [P3W-1:0]      p3;
    logic [NB-1:0]       q3;
    logic [NB-1:0]       three_q;
    logic [NB-1:0]       digit_full;
    logic [DENW-1:0]     sel_a;
    logic [DENW-1:0]     sel_d;
    logic [SIZE_W-1:0]   sel_size;
    logic [DENW:0]       twice;
    logic                neg_now;
    logic [DENW:0]       mag_full;
    logic [NUMD-1:0]     numd;
    logic [DIV_NUMW-1:0] capped;
    logic [JIT_W-1:0]    jit;

    t_div_req             div_req;
    logic [DIV_NUMW-1:0]  div_num;
    logic [DVW-1:0]       div_den;
    logic                 div_done;
    logic [DIV_NUMW-1:0]  div_quo;
    logic [DVW-1:0]       div_rem;

    always_comb begin
        seq_ext   = CW'(r_seq_len);
        len_eff   = (seq_ext > CW'(MAX_SEQUENCE)) ? CW'(MAX_SEQUENCE) : seq_ext;
        zero_case = (r_seq_len < SEQ_W'(2)) || (r_width == '0) || (r_height == '0);

        p3         = P3W'(r_n3) * P3W'(RECIP3);
        q3         = NB'(p3 >> RECIP3_SHIFT);
        three_q    = NB'({q3, 1'b0}) + q3;
        digit_full = r_n3 - three_q;

        sel_a    = r_axis ? r_a3 : r_a2;
        sel_d    = r_axis ? r_d3 : r_d2;
        sel_size = r_axis ? r_height : r_width;
        twice    = {sel_a, 1'b0};
        neg_now  = twice < {1'b0, sel_d};
        mag_full = neg_now ? ({1'b0, sel_d} - twice) : (twice - {1'b0, sel_d});

        numd = (NUMD'(r_mag) << (FRACTION_BITS + 1)) + NUMD'(r_div);

        div_req.start = (r_state == S_MODS) || (r_state == S_DIVS);
        if (r_state == S_MODS) begin
            div_req.steps = DIV_STEPW'(DIV_NUMW);
            div_num       = r_frame;
            div_den       = DVW'(len_eff);
        end else begin
            div_req.steps = DIV_STEPW'(NUMD);
            div_num       = DIV_NUMW'(numd) << (DIV_NUMW - NUMD);
            div_den       = {r_div, 1'b0};
        end

        if (r_neg) begin
            capped = (div_quo > NEG_LIM) ? NEG_LIM : div_quo;
            jit    = JIT_W'(DIV_NUMW'(0) - capped);
        end else begin
            capped = (div_quo > POS_LIM) ? POS_LIM : div_quo;
            jit    = JIT_W'(capped);
        end
    end

    hsj_div #(
        .DVW (DVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= SEQ_LEN_RST;
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEQ_LEN: r_seq_len <= i_cfg_data[SEQ_W-1:0];
                REG_WIDTH:   r_width   <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT:  r_height  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_axis      <= 1'b0;
        end else begin
            if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= zero_case ? S_FIN : S_MODS;
                    end
                end
                S_MODS: r_state <= S_MODW;
                S_MODW: begin
                    if (div_done) begin
                        r_state <= S_RAD;
                    end
                end
                S_RAD: begin
                    if (r_n2 == '0 && r_n3 == '0) begin
                        r_axis  <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL:  r_state <= S_DIVS;
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        r_axis  <= 1'b1;
                        r_state <= r_axis ? S_FIN : S_MUL;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_frame <= i_in.frame_number;
                r_jx    <= '0;
                r_jy    <= '0;
            end
            S_MODW: begin
                r_n2 <= NB'(div_rem) + NB'(1);
                r_n3 <= NB'(div_rem) + NB'(1);
                r_a2 <= '0;
                r_d2 <= DENW'(1);
                r_a3 <= '0;
                r_d3 <= DENW'(1);
            end
            S_RAD: begin
                if (r_n2 != '0) begin
                    r_a2 <= {r_a2[DENW-2:0], r_n2[0]};
                    r_d2 <= {r_d2[DENW-2:0], 1'b0};
                    r_n2 <= r_n2 >> 1;
                end
                if (r_n3 != '0) begin
                    r_a3 <= {r_a3[DENW-2:0], 1'b0} + r_a3 + DENW'(digit_full[1:0]);
                    r_d3 <= {r_d3[DENW-2:0], 1'b0} + r_d3;
                    r_n3 <= q3;
                end
            end
            S_MUL: begin
                r_div <= PRODW'(sel_d) * PRODW'(sel_size);
                r_neg <= neg_now;
                r_mag <= mag_full[DENW-1:0];
            end
            S_DIVW: begin
                if (div_done) begin
                    if (r_axis) begin
                        r_jy <= jit;
                    end else begin
                        r_jx <= jit;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    r_out_x <= r_jx;
                    r_out_y <= r_jy;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.jitter_x = signed'(r_out_x);
    assign o_out.jitter_y = signed'(r_out_y);

endmodule

// ===== test/halton_subpixel_jitter_tb.sv =====
// Self-checking testbench for the Halton subpixel jitter block.
`timescale 1ns / 1ps

module halton_subpixel_jitter_tb;
    import hsj_pkg::*;

    localparam int          FRAC_BITS   = FRACTION_BITS_DEF;
    localparam int          SEQ_MAX     = MAX_SEQUENCE_DEF;
    localparam int          HOLD_CYCLES = 700;
    localparam int          END_PAD     = 200;
    localparam int unsigned LIMIT       = 1_500_000;
    localparam int          PHASES      = 11;

    typedef struct packed {
        logic [JIT_W-1:0] jx;
        logic [JIT_W-1:0] jy;
    } t_jitter_pair;

    class jitter_scoreboard;
        logic [SEQ_W-1:0]  seq_len;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        t_jitter_pair      jitter_due[$];
        int                faults;

        function new();
            seq_len = SEQ_LEN_RST;
            width   = WIDTH_RST;
            height  = HEIGHT_RST;
            faults  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SEQ_LEN: seq_len = data[SEQ_W-1:0];
                REG_WIDTH:   width   = data[SIZE_W-1:0];
                REG_HEIGHT:  height  = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Offset (2*h - 1) / size of the radical inverse h of n, rounded and saturated.
        function logic [JIT_W-1:0] axis_offset(longint unsigned n, longint unsigned base,
                                               longint unsigned size);
            longint unsigned digits, scale, twice, mag, span, q;
            bit              neg;
            digits = 0;
            scale  = 1;
            while (n > 0) begin
                digits = digits * base + n % base;
                scale  = scale * base;
                n      = n / base;
            end
            twice = 2 * digits;
            neg   = twice < scale;
            mag   = neg ? scale - twice : twice - scale;
            span  = scale * size;
            q     = ((mag << (FRAC_BITS + 1)) + span) / (2 * span);
            if (neg) begin
                if (q > 64'h8000_0000) begin
                    q = 64'h8000_0000;
                end
                q = 64'd0 - q;
            end else if (q > 64'h7FFF_FFFF) begin
                q = 64'h7FFF_FFFF;
            end
            return q[JIT_W-1:0];
        endfunction

        function t_jitter_pair halton_jitter(logic [FRAME_W-1:0] frame);
            t_jitter_pair    p;
            longint unsigned len, n;
            p = '0;
            if (seq_len >= 2 && width != 0 && height != 0) begin
                len  = (seq_len > SEQ_MAX) ? 64'(SEQ_MAX) : 64'(seq_len);
                n    = frame % len + 64'd1;
                p.jx = axis_offset(n, 64'd2, 64'(width));
                p.jy = axis_offset(n, 64'd3, 64'(height));
            end
            return p;
        endfunction

        function void note_frame(logic [FRAME_W-1:0] frame);
            jitter_due.push_back(halton_jitter(frame));
        endfunction

        function void flag(string what);
            faults++;
            if (faults <= 10) begin
                $display("%0t: mismatch: %s", $time, what);
            end
        endfunction

        function void check_pair(logic [JIT_W-1:0] x, logic [JIT_W-1:0] y);
            t_jitter_pair want;
            if (jitter_due.size() == 0) begin
                flag($sformatf("unexpected beat x=%0d y=%0d", $signed(x), $signed(y)));
                return;
            end
            want = jitter_due.pop_front();
            if (x !== want.jx) begin
                flag($sformatf("jitter_x expected %0d got %0d", $signed(want.jx), $signed(x)));
            end
            if (y !== want.jy) begin
                flag($sformatf("jitter_y expected %0d got %0d", $signed(want.jy), $signed(y)));
            end
        endfunction

        function int pending();
            return jitter_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hsj_in_if  in_if();
    hsj_out_if out_if();

    halton_subpixel_jitter #(
        .MAX_SEQUENCE  (SEQ_MAX),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    jitter_scoreboard sb = new();
    bit               bursts_on = 1'b1;
    bit               hold_req  = 1'b0;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] seq_data,
                             input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data);
        write_reg(REG_SEQ_LEN, seq_data);
        write_reg(REG_WIDTH, w_data);
        write_reg(REG_HEIGHT, h_data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input logic [FRAME_W-1:0] frame);
        int gap;
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.frame_number <= frame;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_frame(frame);
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end else if (stall_left == 0 && bursts_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                sb.check_pair(out_if.jitter_x, out_if.jitter_y);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.", LIMIT, sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] seq_data, w_data, h_data;
        logic [FRAME_W-1:0]    base, frame;
        int                    count;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.frame_number = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: walk one full cycle of the sequence, then the input extremes.
        for (int k = 0; k <= 8; k++) begin
            send_frame(FRAME_W'(k));
        end
        send_frame('1);
        send_frame({1'b1, {(FRAME_W-1){1'b0}}});
        settle();

        // A sequence length of zero or one gives no jitter.
        configure(15'd0, 15'd1920, 15'd1080);
        send_frame(64'd5);
        settle();
        configure(15'd1, 15'd1920, 15'd1080);
        send_frame(64'd12345);
        settle();

        // Longest sequence on a one-pixel target gives the largest offsets.
        configure(15'd64, 15'd1, 15'd1);
        send_frame(64'd63);
        send_frame(64'd64);
        send_frame('1);
        settle();

        // Lengths above the maximum saturate; upper data bits are dropped.
        configure(15'h7FFF, 15'h7FFF, 15'h7FFF);
        send_frame(64'd63);
        send_frame(64'd127);
        settle();

        // Zero width or zero height gives no jitter.
        configure(15'h7F85, 15'd0, 15'd1080);
        send_frame(64'd3);
        settle();
        configure(15'd8, 15'd1920, 15'd0);
        send_frame(64'd3);
        settle();

        configure(15'd2, 15'd16384, 15'd16384);
        send_frame(64'd0);
        send_frame(64'd1);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 15))
                0:       seq_data = 15'($urandom_range(0, 1));
                1:       seq_data = 15'($urandom_range(65, 127));
                2:       seq_data = 15'd64;
                3:       seq_data = 15'($urandom);
                default: seq_data = 15'($urandom_range(2, 64));
            endcase
            case ($urandom_range(0, 15))
                0:       w_data = 15'd0;
                1:       w_data = 15'd1;
                2:       w_data = 15'h7FFF;
                3:       w_data = 15'd16384;
                default: w_data = 15'($urandom_range(1, 32767));
            endcase
            case ($urandom_range(0, 15))
                0:       h_data = 15'd0;
                1:       h_data = 15'd1;
                2:       h_data = 15'h7FFF;
                3:       h_data = 15'd16384;
                default: h_data = 15'($urandom_range(1, 32767));
            endcase
            configure(seq_data, w_data, h_data);

            bursts_on = (phase != PHASES - 1) && (phase % 4 != 3);
            if (phase == 1 || phase == 5) begin
                hold_req = 1'b1;
            end
            count = (phase == PHASES - 1) ? 200 : 150;
            base  = {$urandom, $urandom};
            for (int k = 0; k < count; k++) begin
                case ($urandom_range(0, 3))
                    0, 1:    frame = base + FRAME_W'(k);
                    2:       frame = {$urandom, $urandom};
                    default: frame = FRAME_W'($urandom_range(0, 200));
                endcase
                send_frame(frame);
            end
            settle();
        end

        repeat (END_PAD) @(negedge i_clk);
        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/hsj_pkg.sv
sv/hsj_ifs.sv
sv/hsj_div.sv
sv/halton_subpixel_jitter.sv
test/halton_subpixel_jitter_tb.sv
